[rtl/core/egcd_pkg.sv]
// Package for the 128-bit extended GCD unit.
// Holds widths, the controller state type and the command/status structs.
// No dependencies.
package egcd_pkg;

  localparam int unsigned WordW = 128;
  localparam int unsigned HalfW = 64;
  localparam int unsigned BitCntW = 7;   // indexes one of 128 quotient bits
  localparam int unsigned MulStepW = 3;  // eight 16-bit digit steps

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CHECK,
    ST_DIV,
    ST_MUL,
    ST_SWAP,
    ST_FINISH,
    ST_OUT
  } egcd_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture operands and take magnitudes
    logic div_start;   // clear remainder and quotient
    logic div_step;    // one shift-subtract step
    logic mul_start;   // clear coefficient products
    logic mul_step;    // one quotient digit into the products
    logic swap;        // advance the Euclid pairs
    logic finish;      // apply signs and the special cases into the result register
  } egcd_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic b_zero;      // divisor is zero: Euclid loop done
    logic early;       // invalid or zero operand: result known at once
  } egcd_status_t;

endpackage

[rtl/core/egcd_ctrl.sv]
// Controller state machine for the extended GCD unit.
// Depends on egcd_pkg.
module egcd_ctrl
  import egcd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  egcd_status_t status,
  output egcd_cmd_t    cmd
);

  egcd_state_t state, state_next;
  logic [BitCntW-1:0] count, count_next;

  // hold state and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // decode next state and commands
  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // refuse transactions while in reset
        in_stall = rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_LOAD: state_next = ST_CHECK;
      ST_CHECK: begin
        if (status.early || status.b_zero) begin
          state_next = ST_FINISH;
        end else begin
          cmd.div_start = 1'b1;
          count_next    = '1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        count_next   = count - 1'b1;
        if (count == '0) begin
          cmd.mul_start = 1'b1;
          count_next    = '0;
          state_next    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        count_next   = count + 1'b1;
        if (count[MulStepW-1:0] == '1) state_next = ST_SWAP;
      end
      ST_SWAP: begin
        cmd.swap   = 1'b1;
        state_next = ST_CHECK;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

[rtl/core/egcd_datapath.sv]
// Datapath for the extended GCD unit: shift-subtract divider, digit-serial
// multiply-subtract of the coefficients, sign handling and result register.
// Depends on egcd_pkg.
module egcd_datapath
  import egcd_pkg::*;
(
  input  logic                   clk,
  input  egcd_cmd_t              cmd,
  input  logic signed [HalfW-1:0] u_high,
  input  logic [HalfW-1:0]       u_low,
  input  logic signed [HalfW-1:0] v_high,
  input  logic [HalfW-1:0]       v_low,
  output egcd_status_t           status,
  output logic [WordW-1:0]       g_res,
  output logic [WordW-1:0]       s_res,
  output logic [WordW-1:0]       t_res,
  output logic                   inv_res
);

  localparam logic [WordW-1:0] MinVal = {1'b1, {(WordW-1){1'b0}}};
  localparam logic [WordW-1:0] One = {{(WordW-1){1'b0}}, 1'b1};

  logic [WordW-1:0] a, b, s, t, x, y, q, r, n, qx, qy;
  logic [WordW-1:0] u_raw, v_raw;
  logic             un, vn, inv, early;
  logic [WordW:0]   r_shift;
  logic [WordW:0]   r_diff;
  logic [15:0]      digit;
  logic [WordW+15:0] px, py;

  // join the operand halves
  assign u_raw = {u_high, u_low};
  assign v_raw = {v_high, v_low};

  // one divider step: shift in the next dividend bit, try to subtract
  assign r_shift = {r, n[WordW-1]};
  assign r_diff  = r_shift - {1'b0, b};

  // next 16-bit quotient digit, most significant first
  assign digit = q[WordW-1 -: 16];
  assign px = {qx, 16'd0} + 144'(digit) * 144'(x);
  assign py = {qy, 16'd0} + 144'(digit) * 144'(y);

  assign status.b_zero = (b == '0);
  assign status.early  = early;

  always_ff @(posedge clk) begin
    // capture operands, take magnitudes
    if (cmd.load) begin
      un  <= u_raw[WordW-1];
      vn  <= v_raw[WordW-1];
      inv <= (u_raw == MinVal) || (v_raw == MinVal);
      a   <= u_raw[WordW-1] ? -u_raw : u_raw;
      b   <= v_raw[WordW-1] ? -v_raw : v_raw;
      early <= (u_raw == MinVal) || (v_raw == MinVal) || (u_raw == '0) ||
               (v_raw == '0);
      s <= One;
      t <= '0;
      x <= '0;
      y <= One;
    end
    // start a division of a by b
    if (cmd.div_start) begin
      n <= a;
      r <= '0;
      q <= '0;
    end
    // advance one quotient bit
    if (cmd.div_step) begin
      n <= {n[WordW-2:0], 1'b0};
      if (!r_diff[WordW]) begin
        r <= r_diff[WordW-1:0];
        q <= {q[WordW-2:0], 1'b1};
      end else begin
        r <= r_shift[WordW-1:0];
        q <= {q[WordW-2:0], 1'b0};
      end
    end
    // form q*x and q*y one digit at a time (modulo 2^128)
    if (cmd.mul_start) begin
      qx <= '0;
      qy <= '0;
    end
    if (cmd.mul_step) begin
      qx <= px[WordW-1:0];
      qy <= py[WordW-1:0];
      q  <= {q[WordW-17:0], 16'd0};
    end
    // advance the Euclid pairs
    if (cmd.swap) begin
      a <= b;
      b <= r;
      s <= x;
      x <= s - qx;
      t <= y;
      y <= t - qy;
    end
    // form the result, special cases first
    if (cmd.finish) begin
      inv_res <= inv;
      if (inv) begin
        g_res <= '0;
        s_res <= '0;
        t_res <= '0;
      end else if (a == '0) begin
        g_res <= b;
        s_res <= '0;
        t_res <= vn ? '1 : One;
      end else if (b == '0 && early) begin
        g_res <= a;
        s_res <= un ? '1 : One;
        t_res <= '0;
      end else begin
        g_res <= a;
        s_res <= un ? -s : s;
        t_res <= vn ? -t : t;
      end
    end
  end

endmodule

[rtl/core/extended_gcd_128_unit.sv]
// Extended GCD unit for signed 128-bit operands: g = gcd(|u|,|v|) and s, t
// with s*u + t*v = g. One operand pair at a time. Each Euclid iteration runs
// 128 quotient bits through the bit-serial divider, then 8 digits through the
// 16-bit digit multiplier, then the swap and check states (k iterations, k at
// most about 185 for 128-bit Fibonacci operands). Either operand equal
// to -2^127 gives input_invalid with all results zero.
module extended_gcd_128_unit
  import egcd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [HalfW-1:0] u_high,
  input  logic [HalfW-1:0]        u_low,
  input  logic signed [HalfW-1:0] v_high,
  input  logic [HalfW-1:0]        v_low,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [HalfW-2:0]        g_high,
  output logic [HalfW-1:0]        g_low,
  output logic signed [HalfW-1:0] s_high,
  output logic [HalfW-1:0]        s_low,
  output logic signed [HalfW-1:0] t_high,
  output logic [HalfW-1:0]        t_low,
  output logic                    input_invalid
);

  egcd_cmd_t        cmd;
  egcd_status_t     status;
  logic [WordW-1:0] g_res, s_res, t_res;

  egcd_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .status, .cmd
  );

  egcd_datapath u_dp (
    .clk, .cmd, .u_high, .u_low, .v_high, .v_low, .status,
    .g_res, .s_res, .t_res, .inv_res(input_invalid)
  );

  // split results into halves
  assign g_high = g_res[WordW-2:HalfW];
  assign g_low  = g_res[HalfW-1:0];
  assign s_high = s_res[WordW-1:HalfW];
  assign s_low  = s_res[HalfW-1:0];
  assign t_high = t_res[WordW-1:HalfW];
  assign t_low  = t_res[HalfW-1:0];

`ifndef SYNTH
  // a transaction is never taken while a result is pending
  assert property (@(posedge clk) disable iff (rst) out_valid |-> in_stall)
    else $error("input taken while result pending");
  // a result, once shown, stays until taken
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(g_low) && $stable(s_low))
    else $error("result dropped while stalled");
  // invalid results are zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid && input_invalid |-> g_low == '0 && s_low == '0 && t_low == '0)
    else $error("invalid result not zero");
`endif

endmodule

[sim/egcd_checker.sv]
// Checker for the 128-bit extended GCD unit: watches both channels, predicts
// g, s, t and the invalid flag for each accepted operand pair and compares.
// Depends on egcd_pkg for the half-word width.
`timescale 1ns / 100ps
module egcd_checker
  import egcd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [HalfW-1:0]        u_high,
  input  logic [HalfW-1:0]        u_low,
  input  logic [HalfW-1:0]        v_high,
  input  logic [HalfW-1:0]        v_low,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [HalfW-2:0]        g_high,
  input  logic [HalfW-1:0]        g_low,
  input  logic [HalfW-1:0]        s_high,
  input  logic [HalfW-1:0]        s_low,
  input  logic [HalfW-1:0]        t_high,
  input  logic [HalfW-1:0]        t_low,
  input  logic                    input_invalid,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic [WordW-1:0] g;
    logic [WordW-1:0] s;
    logic [WordW-1:0] t;
    logic             inv;
  } gcd_result_t;

  gcd_result_t gcd_expected[$];

  localparam logic [WordW-1:0] MostNeg = {1'b1, {(WordW-1){1'b0}}};

  // extended Euclid on magnitudes, signs applied afterwards, all modulo 2^128
  function automatic gcd_result_t bezout(logic [WordW-1:0] u, logic [WordW-1:0] v);
    gcd_result_t res;
    logic [WordW-1:0] a, b, s, t, x, y, q, r, nx, ny;
    logic un, vn;
    res = '0;
    un = u[WordW-1];
    vn = v[WordW-1];
    if (u == MostNeg || v == MostNeg) begin
      res.inv = 1'b1;
      return res;
    end
    a = un ? -u : u;
    b = vn ? -v : v;
    if (a == 0) begin
      res.g = b;
      res.t = vn ? -128'd1 : 128'd1;
      return res;
    end
    if (b == 0) begin
      res.g = a;
      res.s = un ? -128'd1 : 128'd1;
      return res;
    end
    s = 128'd1; t = '0; x = '0; y = 128'd1;
    while (b != 0) begin
      q = a / b;
      r = a % b;
      a = b;
      b = r;
      nx = s - q * x; s = x; x = nx;
      ny = t - q * y; t = y; y = ny;
    end
    res.g = a;
    res.s = un ? -s : s;
    res.t = vn ? -t : t;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [WordW-1:0] got, logic [WordW-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  // predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    gcd_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall)
        gcd_expected = {gcd_expected, bezout({u_high, u_low}, {v_high, v_low})};
      if (out_valid && !out_stall) begin
        if (gcd_expected.size() == 0) begin
          report_mismatch("unexpected result transaction", '0, '0);
        end else begin
          want = gcd_expected.pop_front();
          if ({1'b0, g_high, g_low} != want.g) report_mismatch("g", {1'b0, g_high, g_low}, want.g);
          if ({s_high, s_low} != want.s) report_mismatch("s", {s_high, s_low}, want.s);
          if ({t_high, t_low} != want.t) report_mismatch("t", {t_high, t_low}, want.t);
          if (input_invalid != want.inv)
            report_mismatch("invalid", 128'(input_invalid), 128'(want.inv));
        end
      end
    end
    pending = gcd_expected.size();
  end

endmodule

[sim/testbench.sv]
// Top of the extended GCD testbench: clock, reset, operand stimulus, output
// stalls and verdict. Depends on egcd_pkg, extended_gcd_128_unit, egcd_checker.
`timescale 1ns / 100ps
module testbench;
  import egcd_pkg::*;

  localparam int IdleLimit = 200000;
  localparam logic [WordW-1:0] MostNeg = {1'b1, {(WordW-1){1'b0}}};

  logic clk, rst, in_valid, in_stall, out_valid, out_stall, input_invalid;
  logic [HalfW-1:0] u_high, u_low, v_high, v_low, s_high, s_low, t_high, t_low, g_low;
  logic [HalfW-2:0] g_high;
  int fail_count, pending;
  int send_idle_pct, recv_idle_pct, hold_off;
  int quiet_cycles;

  extended_gcd_128_unit uut (.*);

  egcd_checker check (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // random 128-bit value with a random effective size, mostly small
  function automatic logic [WordW-1:0] rand_operand();
    logic [WordW-1:0] x;
    int bits;
    x = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(0, 9))
      0: bits = 128;
      1: bits = $urandom_range(65, 127);
      2, 3: bits = $urandom_range(1, 64);
      default: bits = $urandom_range(1, 24);
    endcase
    if (bits < 128) x = x & ((128'd1 << bits) - 128'd1);
    if ($urandom_range(0, 1)) x = -x;
    if ($urandom_range(0, 30) == 0) x = '0;
    return x;
  endfunction

  // offer one operand pair and hold it until accepted; idle before it
  task automatic send_pair(logic [WordW-1:0] u, logic [WordW-1:0] v);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {u_high, u_low} <= u;
    {v_high, v_low} <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // receiver stalls, with one long hold-off on request
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > IdleLimit) begin
      $display("** extended_gcd_128_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [WordW-1:0] f0, f1, f2;
    in_valid = 1'b0; out_stall = 1'b0; hold_off = 0; quiet_cycles = 0;
    u_high = '0; u_low = '0; v_high = '0; v_low = '0;
    send_idle_pct = 0; recv_idle_pct = 0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, zeros, most negative, Fibonacci worst case
    send_pair('0, '0);
    send_pair('0, 128'd5);
    send_pair('0, -128'd5);
    send_pair(128'd7, '0);
    send_pair(-128'd7, '0);
    send_pair(MostNeg, 128'd3);
    send_pair(128'd3, MostNeg);
    send_pair(MostNeg, MostNeg);
    send_pair(MostNeg - 128'd1, MostNeg + 128'd1);
    send_pair({1'b0, {127{1'b1}}}, {1'b0, {127{1'b1}}} - 128'd1);
    send_pair(-128'd1, -128'd1);
    send_pair(128'd12, -128'd18);
    send_pair(-128'd240, 128'd46);
    send_pair({64'hFFFF_FFFF_FFFF_FFFF, 64'h0}, {64'h0, 64'hFFFF_FFFF_FFFF_FFFF});
    f0 = 128'd1; f1 = 128'd1;
    while (f0 + f1 < MostNeg) begin
      f2 = f0 + f1; f0 = f1; f1 = f2;
    end
    send_pair(f1, f0);
    send_pair(-f1, f0);
    // random phases with changing idle mix
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 48 : 0;
      recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 16 : 0;
      if (phase == 1) hold_off = 3000;
      for (int i = 0; i < 460; i++) send_pair(rand_operand(), rand_operand());
    end
    in_valid <= 1'b0;
    // drain and settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("** extended_gcd_128_unit: PASSED **");
    else $display("** extended_gcd_128_unit: FAILED **");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/egcd_pkg.sv
rtl/core/egcd_ctrl.sv
rtl/core/egcd_datapath.sv
rtl/core/extended_gcd_128_unit.sv
sim/egcd_checker.sv
sim/testbench.sv
